FILE: sv/htil_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htil_pkg
// Shared types, character codes and hex helpers for the hex text image loader.
// ----------------------------------------------------------------------------
package htil_pkg;

    // Default cap on data tokens taken from one line
    localparam int HTIL_TOKENS_PER_LINE = 16;
    localparam int HTIL_SEEN_W          = 5;

    // Character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_Q     = 8'h71;

    // Result kinds
    localparam logic [1:0] RK_WRITE = 2'd0;
    localparam logic [1:0] RK_OK    = 2'd1;
    localparam logic [1:0] RK_ERR   = 2'd2;

    typedef enum logic [2:0] {
        PH_LINE,
        PH_ADDR,
        PH_ADDR_HOLD,
        PH_DATA,
        PH_SKIP,
        PH_DONE
    } htil_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } htil_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic        last;
    } htil_out_t;

    typedef struct packed {
        logic [31:0] acc;
        logic        bad;
    } htil_hex_t;

    // True for 0-9 and uppercase A-F: the only legal data line lead
    function automatic logic is_data_lead(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
        return r;
    endfunction

    // Shift one character into a hex accumulator, flagging bad input or bit 31
    function automatic htil_hex_t hex_feed(input logic [31:0] acc, input logic bad,
                                           input logic [7:0] c);
        htil_hex_t  r;
        logic [3:0] d;
        logic       ok;
        r.acc = acc;
        r.bad = bad;
        d     = 4'd0;
        ok    = 1'b1;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            d = 4'(c - 8'h30);
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            d = 4'(c - 8'h37);
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            d = 4'(c - 8'h57);
        end
        else
        begin
            ok = 1'b0;
        end
        if (!bad)
        begin
            if (!ok)
            begin
                r.bad = 1'b1;
            end
            else
            begin
                r.acc = {acc[27:0], d};
                r.bad = r.acc[31];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/hex_text_image_loader_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_text_image_loader_top
// Parses a text hex image one character per request and emits byte writes
// followed by a single final status.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid / in_ready   | in_data  (htil_in_t)
//  out     | output    | out_valid / out_ready | out_data (htil_out_t)
//
//  One character request is taken per cycle while in_ready is high; the parser
//  state updates at the accepting edge and the 0, 1 or 2 results go into a
//  four-entry result queue, offered from the next cycle on.
//  in_ready drops only while the queue has fewer than two free entries, so a
//  stalled output side holds the input once three or more results are pending.
//  rst_n clears the parser to line start, address zero, and empties the queue.
//  After a final status every further request is taken and dropped.
// ----------------------------------------------------------------------------
module hex_text_image_loader_top
    import htil_pkg::*;
#(
    parameter int TOKENS_PER_LINE = HTIL_TOKENS_PER_LINE
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire htil_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output htil_out_t      out_data
);

    localparam logic [HTIL_SEEN_W-1:0] TOK_LIMIT = HTIL_SEEN_W'(TOKENS_PER_LINE);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Parser state
    htil_phase_t             phase_reg, phase_next;
    logic [31:0]             addr_reg, addr_next;
    logic [31:0]             acc_reg, acc_next;
    logic                    open_reg, open_next;
    logic                    bad_reg, bad_next;
    logic [HTIL_SEEN_W-1:0]  seen_reg, seen_next;

    // Result queue
    htil_out_t               q_mem [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]       cnt_reg;

    logic                    in_fire, out_fire, live;
    logic [7:0]              c;

    // Token close outcome
    logic                    cl_emit, cl_skip;
    logic [31:0]             cl_addr;
    logic [HTIL_SEEN_W-1:0]  cl_seen;

    // Data character outcome
    htil_hex_t               dc_hex;
    logic [31:0]             dc_acc_base;
    logic                    dc_bad_base;
    htil_hex_t               ad_hex;

    // Result slots
    logic                    s0_v, s1_v;
    htil_out_t               s0, s1;

    assign c        = in_data.ch;
    assign in_ready = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign in_fire  = in_valid && in_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_fire = out_valid && out_ready;
    assign out_data = q_mem[rd_ptr_reg];
    assign live     = in_fire && (phase_reg != PH_DONE);

    // Close an open token: write if under the limit, skip once the limit is hit
    always_comb
    begin
        cl_emit = open_reg && (seen_reg < TOK_LIMIT);
        cl_seen = cl_emit ? (seen_reg + 1'b1) : seen_reg;
        cl_addr = cl_emit ? (addr_reg + 32'd1) : addr_reg;
        cl_skip = open_reg && (cl_seen >= TOK_LIMIT);
    end

    // Feed one character into a token, opening it first if needed
    always_comb
    begin
        dc_acc_base = open_reg ? acc_reg : 32'd0;
        dc_bad_base = open_reg ? bad_reg : 1'b0;
        dc_hex      = hex_feed(dc_acc_base, dc_bad_base, c);
        ad_hex      = hex_feed(acc_reg, bad_reg, c);
    end

    // Next parser state
    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        acc_next   = acc_reg;
        open_next  = open_reg;
        bad_next   = bad_reg;
        seen_next  = seen_reg;
        if (live)
        begin
            if (in_data.kind)
            begin
                phase_next = PH_DONE;
                if (phase_reg == PH_DATA)
                begin
                    open_next = 1'b0;
                    addr_next = cl_addr;
                    seen_next = cl_seen;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LINE:
                    begin
                        if (c == CH_Q)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (c == CH_AT)
                        begin
                            phase_next = PH_ADDR;
                            bad_next   = 1'b0;
                            acc_next   = 32'd0;
                        end
                        else if (is_data_lead(c))
                        begin
                            seen_next  = '0;
                            acc_next   = dc_hex.acc;
                            bad_next   = dc_hex.bad;
                            open_next  = !dc_hex.bad;
                            phase_next = dc_hex.bad ? PH_SKIP : PH_DATA;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_ADDR, PH_ADDR_HOLD:
                    begin
                        if (c == CH_NL)
                        begin
                            if (bad_reg || (acc_reg == 32'd0))
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                addr_next  = acc_reg;
                                phase_next = PH_LINE;
                                open_next  = 1'b0;
                                bad_next   = 1'b0;
                                acc_next   = 32'd0;
                                seen_next  = '0;
                            end
                        end
                        else if (c == CH_NUL)
                        begin
                            phase_next = PH_ADDR_HOLD;
                        end
                        else if (phase_reg == PH_ADDR)
                        begin
                            acc_next = ad_hex.acc;
                            bad_next = ad_hex.bad;
                        end
                    end
                    PH_DATA:
                    begin
                        if (c == CH_NL)
                        begin
                            addr_next  = cl_addr;
                            phase_next = PH_LINE;
                            open_next  = 1'b0;
                            bad_next   = 1'b0;
                            acc_next   = 32'd0;
                            seen_next  = '0;
                        end
                        else if ((c == CH_SPACE) || (c == CH_NUL))
                        begin
                            open_next = 1'b0;
                            addr_next = cl_addr;
                            seen_next = cl_seen;
                            if (cl_skip || (c == CH_NUL))
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                        else
                        begin
                            acc_next  = dc_hex.acc;
                            bad_next  = dc_hex.bad;
                            open_next = !dc_hex.bad;
                            if (dc_hex.bad)
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        if (c == CH_NL)
                        begin
                            phase_next = PH_LINE;
                            open_next  = 1'b0;
                            bad_next   = 1'b0;
                            acc_next   = 32'd0;
                            seen_next  = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Results for this request
    always_comb
    begin
        s0_v = 1'b0;
        s1_v = 1'b0;
        s0   = '{result_kind: RK_WRITE, write_address: addr_reg,
                 write_data: acc_reg[7:0], last: 1'b1};
        s1   = '{result_kind: RK_ERR, write_address: 32'd0,
                 write_data: 8'd0, last: 1'b1};
        if (live)
        begin
            if (in_data.kind)
            begin
                if ((phase_reg == PH_DATA) && cl_emit)
                begin
                    s0_v    = 1'b1;
                    s0.last = 1'b0;
                    s1_v    = 1'b1;
                end
                else
                begin
                    s0_v = 1'b1;
                    s0   = s1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LINE:
                    begin
                        if (c == CH_Q)
                        begin
                            s0_v = 1'b1;
                            s0   = '{result_kind: RK_OK, write_address: 32'd0,
                                     write_data: 8'd0, last: 1'b1};
                        end
                        else if ((c != CH_AT) && !is_data_lead(c))
                        begin
                            s0_v = 1'b1;
                            s0   = s1;
                        end
                    end
                    PH_ADDR, PH_ADDR_HOLD:
                    begin
                        if ((c == CH_NL) && (bad_reg || (acc_reg == 32'd0)))
                        begin
                            s0_v = 1'b1;
                            s0   = s1;
                        end
                    end
                    PH_DATA:
                    begin
                        if ((c == CH_NL) || (c == CH_SPACE) || (c == CH_NUL))
                        begin
                            s0_v = cl_emit;
                        end
                    end
                    default:
                    begin
                        s0_v = 1'b0;
                    end
                endcase
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE;
            addr_reg  <= 32'd0;
            acc_reg   <= 32'd0;
            open_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            seen_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            acc_reg   <= acc_next;
            open_reg  <= open_next;
            bad_reg   <= bad_next;
            seen_reg  <= seen_next;
        end
    end

    // Push results into the queue
    always_ff @(posedge clk)
    begin
        if (s0_v)
        begin
            q_mem[wr_ptr_reg] <= s0;
        end
        if (s1_v)
        begin
            q_mem[wr_ptr_reg + 1'b1] <= s1;
        end
    end

    // Advance queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'({1'b0, s0_v} + {1'b0, s1_v});
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(out_fire);
            cnt_reg    <= cnt_reg + QCNT_W'(s0_v) + QCNT_W'(s1_v) - QCNT_W'(out_fire);
        end
    end

endmodule

`default_nettype wire
